>>> hdl/rsob_pkg.sv
// Shared types, constants and the divide-by-255 helper for the RGBA source-over blender.
`default_nettype none
package rsob_pkg;

    localparam logic [16:0] C_ONE_Q16  = 17'd65536;
    localparam logic [24:0] C_HALF_Q16 = 25'd32768;
    localparam logic [7:0]  C_MAX8     = 8'd255;
    localparam logic [15:0] C_RND      = 16'd127;
    localparam int          C_LATENCY  = 5;

    // Channel order in the packed arrays: 0 red, 1 green, 2 blue, 3 alpha.
    localparam int C_ALPHA = 3;

    typedef struct packed {
        logic [7:0]  paint_red;
        logic [7:0]  paint_green;
        logic [7:0]  paint_blue;
        logic [7:0]  paint_alpha;
        logic [16:0] paint_opacity;
        logic        paint_covered;
        logic [7:0]  dest_red;
        logic [7:0]  dest_green;
        logic [7:0]  dest_blue;
        logic [7:0]  dest_alpha;
    } t_item;

    // After the product stage.
    typedef struct packed {
        logic             valid;
        logic             wr;
        logic             lock;
        logic [7:0]       ea;
        logic [3:0][7:0]  dst;
        logic [2:0][15:0] m_src;
        logic [3:0][15:0] m_dst;
    } t_s2;

    // After the divide stage.
    typedef struct packed {
        logic             valid;
        logic             wr;
        logic             lock;
        logic [7:0]       ea;
        logic [3:0][7:0]  dst;
        logic [2:0][15:0] m_dst;
        logic [2:0][7:0]  q_src;
        logic [3:0][7:0]  q_dst;
    } t_s3;

    typedef struct packed {
        logic             valid;
        logic [3:0][7:0]  px;
        logic             wr;
    } t_res;

    // Rounded-in-advance floor(t / 255) for t < 65280: reciprocal estimate, then one
    // correction step (the estimate is never high and at most one low).
    function automatic logic [7:0] div255(input logic [15:0] t);
        logic [16:0] acc;
        logic [7:0]  q;
        logic [16:0] rem;
        acc = {1'b0, t} + {9'd0, t[15:8]};
        q   = acc[15:8];
        rem = {1'b0, t} - (({9'd0, q} << 8) - {9'd0, q});
        if (rem >= 17'd255) begin
            q = q + 8'd1;
        end
        return q;
    endfunction

endpackage
`default_nettype wire

>>> hdl/rsob_front.sv
// Opacity clamp, effective alpha and the first row of channel products.
`default_nettype none
module rsob_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_lock,
    input  wire rsob_pkg::t_item i_item,
    output rsob_pkg::t_s2        o_s2
);

    logic            r_v1;
    rsob_pkg::t_item r_item1;
    logic            r_lock1;
    logic [24:0]     r_prod1;

    logic [16:0]     n_opc;
    logic [24:0]     n_prod1;
    rsob_pkg::t_s2   n_s2;
    rsob_pkg::t_s2   r_s2;

    logic [24:0]     w_sum;
    logic [7:0]      w_ea;
    logic [7:0]      w_inv;
    logic [7:0]      w_mul;
    logic [2:0][7:0] w_src;

    always_comb begin
        n_opc   = (i_item.paint_opacity > rsob_pkg::C_ONE_Q16) ? rsob_pkg::C_ONE_Q16
                                                               : i_item.paint_opacity;
        n_prod1 = {17'd0, i_item.paint_alpha} * {8'd0, n_opc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start;
        end
        r_item1 <= i_item;
        r_lock1 <= i_lock;
        r_prod1 <= n_prod1;
    end

    always_comb begin
        // product is at most 255 * 65536, so the rounded value fits bits 23:16
        w_sum = r_prod1 + rsob_pkg::C_HALF_Q16;
        w_ea  = w_sum[23:16];
        w_inv = rsob_pkg::C_MAX8 - w_ea;
        w_mul = r_lock1 ? r_item1.dest_alpha : w_ea;
        w_src = {r_item1.paint_blue, r_item1.paint_green, r_item1.paint_red};

        n_s2.valid = r_v1;
        n_s2.wr    = r_item1.paint_covered && (r_item1.paint_opacity != 17'd0)
                     && (r_item1.paint_alpha != 8'd0)
                     && (!r_lock1 || (r_item1.dest_alpha != 8'd0));
        n_s2.lock  = r_lock1;
        n_s2.ea    = w_ea;
        n_s2.dst   = {r_item1.dest_alpha, r_item1.dest_blue,
                      r_item1.dest_green, r_item1.dest_red};
        for (int i = 0; i < 3; i++) begin
            n_s2.m_src[i] = {8'd0, w_src[i]} * {8'd0, w_mul};
        end
        for (int i = 0; i < 4; i++) begin
            n_s2.m_dst[i] = {8'd0, n_s2.dst[i]} * {8'd0, w_inv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= n_s2.valid;
        end
        r_s2.wr    <= n_s2.wr;
        r_s2.lock  <= n_s2.lock;
        r_s2.ea    <= n_s2.ea;
        r_s2.dst   <= n_s2.dst;
        r_s2.m_src <= n_s2.m_src;
        r_s2.m_dst <= n_s2.m_dst;
    end

    assign o_s2 = r_s2;

endmodule
`default_nettype wire

>>> hdl/rsob_div.sv
// Rounded divide-by-255 of every product, all channels in parallel.
`default_nettype none
module rsob_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rsob_pkg::t_s2 i_s2,
    output rsob_pkg::t_s3      o_s3
);

    rsob_pkg::t_s3 n_s3;
    rsob_pkg::t_s3 r_s3;

    always_comb begin
        n_s3.valid = i_s2.valid;
        n_s3.wr    = i_s2.wr;
        n_s3.lock  = i_s2.lock;
        n_s3.ea    = i_s2.ea;
        n_s3.dst   = i_s2.dst;
        for (int i = 0; i < 3; i++) begin
            n_s3.m_dst[i] = i_s2.m_dst[i];
            n_s3.q_src[i] = rsob_pkg::div255(i_s2.m_src[i] + rsob_pkg::C_RND);
        end
        for (int i = 0; i < 4; i++) begin
            n_s3.q_dst[i] = rsob_pkg::div255(i_s2.m_dst[i] + rsob_pkg::C_RND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else begin
            r_s3.valid <= n_s3.valid;
        end
        r_s3.wr    <= n_s3.wr;
        r_s3.lock  <= n_s3.lock;
        r_s3.ea    <= n_s3.ea;
        r_s3.dst   <= n_s3.dst;
        r_s3.m_dst <= n_s3.m_dst;
        r_s3.q_src <= n_s3.q_src;
        r_s3.q_dst <= n_s3.q_dst;
    end

    assign o_s3 = r_s3;

endmodule
`default_nettype wire

>>> hdl/rsob_back.sv
// Composite or locked mix, final divide, skip pass-through and the output register.
`default_nettype none
module rsob_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rsob_pkg::t_s3 i_s3,
    output rsob_pkg::t_res     o_res
);

    logic             r_v4;
    logic             r_wr4;
    logic             r_lock4;
    logic [3:0][7:0]  r_dst4;
    logic [2:0][15:0] r_w4;
    logic [7:0]       r_alpha4;

    logic [2:0][15:0] n_w4;
    logic [7:0]       n_alpha4;
    logic [8:0]       w_nsum;
    logic [8:0]       w_asum;
    logic [15:0]      w_lprod;

    rsob_pkg::t_res   n_res;
    rsob_pkg::t_res   r_res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_nsum  = {1'b0, i_s3.q_src[i]} + {1'b0, i_s3.q_dst[i]};
            w_lprod = {8'd0, i_s3.q_src[i]} * {8'd0, i_s3.ea};
            if (i_s3.lock) begin
                // sum stays within 255 * 255 + 127, so no carry out of 16 bits
                n_w4[i] = w_lprod + i_s3.m_dst[i] + rsob_pkg::C_RND;
            end else begin
                n_w4[i] = w_nsum[8] ? {8'd0, rsob_pkg::C_MAX8} : {8'd0, w_nsum[7:0]};
            end
        end
        w_asum = {1'b0, i_s3.ea} + {1'b0, i_s3.q_dst[rsob_pkg::C_ALPHA]};
        if (i_s3.lock) begin
            n_alpha4 = i_s3.dst[rsob_pkg::C_ALPHA];
        end else begin
            n_alpha4 = w_asum[8] ? rsob_pkg::C_MAX8 : w_asum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= i_s3.valid;
        end
        r_wr4    <= i_s3.wr;
        r_lock4  <= i_s3.lock;
        r_dst4   <= i_s3.dst;
        r_w4     <= n_w4;
        r_alpha4 <= n_alpha4;
    end

    always_comb begin
        n_res.valid = r_v4;
        n_res.wr    = r_wr4;
        if (!r_wr4) begin
            n_res.px = r_dst4;
        end else begin
            for (int i = 0; i < 3; i++) begin
                n_res.px[i] = r_lock4 ? rsob_pkg::div255(r_w4[i]) : r_w4[i][7:0];
            end
            n_res.px[rsob_pkg::C_ALPHA] = r_alpha4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= n_res.valid;
        end
        r_res.px <= n_res.px;
        r_res.wr <= n_res.wr;
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

>>> hdl/rgba_source_over_blender_unit.sv
// Top level of the RGBA8 source-over paint blender.
//
// Usage: present one paint/destination pixel with i_start high; busy never rises,
// so an item is taken on every cycle that start is high, one pixel per clock.
// Each item gives exactly one result, shown for one cycle with o_valid high.
// Each item passes through 5 register stages (alpha product, channel products,
// divide by 255, mix, final divide/output register) before o_valid rises.
// Results leave in the order items entered; the receiver cannot stall, so no
// back-pressure exists and the pipeline never holds.
// Configuration: i_cfg_we writes i_cfg_data into alpha_lock at the clock edge;
// write it only while no item is in flight. Each item carries the mode it
// entered with.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears alpha_lock.
// Skipped pixels (no coverage, zero opacity or alpha, or a locked transparent
// destination) return the destination with o_was_written low.
`default_nettype none
module rgba_source_over_blender_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    input  wire logic [7:0]  i_paint_red,
    input  wire logic [7:0]  i_paint_green,
    input  wire logic [7:0]  i_paint_blue,
    input  wire logic [7:0]  i_paint_alpha,
    input  wire logic [16:0] i_paint_opacity,
    input  wire logic        i_paint_covered,
    input  wire logic [7:0]  i_dest_red,
    input  wire logic [7:0]  i_dest_green,
    input  wire logic [7:0]  i_dest_blue,
    input  wire logic [7:0]  i_dest_alpha,
    output logic             o_valid,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic [7:0]       o_out_alpha,
    output logic             o_was_written
);

    logic            r_alpha_lock;
    rsob_pkg::t_item w_item;
    rsob_pkg::t_s2   w_s2;
    rsob_pkg::t_s3   w_s3;
    rsob_pkg::t_res  w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_lock <= 1'b0;
        end else if (i_cfg_we) begin
            r_alpha_lock <= i_cfg_data;
        end
    end

    always_comb begin
        w_item.paint_red     = i_paint_red;
        w_item.paint_green   = i_paint_green;
        w_item.paint_blue    = i_paint_blue;
        w_item.paint_alpha   = i_paint_alpha;
        w_item.paint_opacity = i_paint_opacity;
        w_item.paint_covered = i_paint_covered;
        w_item.dest_red      = i_dest_red;
        w_item.dest_green    = i_dest_green;
        w_item.dest_blue     = i_dest_blue;
        w_item.dest_alpha    = i_dest_alpha;
    end

    rsob_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_lock  (r_alpha_lock),
        .i_item  (w_item),
        .o_s2    (w_s2)
    );

    rsob_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s2    (w_s2),
        .o_s3    (w_s3)
    );

    rsob_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s3    (w_s3),
        .o_res   (w_res)
    );

    assign o_busy        = 1'b0;
    assign o_valid       = w_res.valid;
    assign o_out_red     = w_res.px[0];
    assign o_out_green   = w_res.px[1];
    assign o_out_blue    = w_res.px[2];
    assign o_out_alpha   = w_res.px[rsob_pkg::C_ALPHA];
    assign o_was_written = w_res.wr;

endmodule
`default_nettype wire

>>> hdl/rsob_checker.sv
// Port-level checks for the blender, bound to the top level.
`default_nettype none
module rsob_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic [7:0]  i_paint_alpha,
    input wire logic        i_paint_covered,
    input wire logic [7:0]  i_dest_red,
    input wire logic [7:0]  i_dest_alpha,
    input wire logic        o_valid,
    input wire logic [7:0]  o_out_red,
    input wire logic [7:0]  o_out_alpha,
    input wire logic        o_was_written
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##5 o_valid) else $error("item lost in pipeline");

    a_skip_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_was_written) |->
            (o_out_red == $past(i_dest_red, 5)) && (o_out_alpha == $past(i_dest_alpha, 5)))
        else $error("skipped item changed destination");

    a_written_needs_paint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_written) |->
            ($past(i_paint_covered, 5) && ($past(i_paint_alpha, 5) != 8'd0)))
        else $error("uncovered item marked written");

endmodule

bind rgba_source_over_blender_unit rsob_checker u_rsob_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .i_paint_alpha   (i_paint_alpha),
    .i_paint_covered (i_paint_covered),
    .i_dest_red      (i_dest_red),
    .i_dest_alpha    (i_dest_alpha),
    .o_valid         (o_valid),
    .o_out_red       (o_out_red),
    .o_out_alpha     (o_out_alpha),
    .o_was_written   (o_was_written)
);
`default_nettype wire

>>> tb/rgba_source_over_blender_unit_test.sv
// Self-checking testbench for the RGBA8 source-over paint blender.
module rgba_source_over_blender_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FULL8    = 255;
    localparam int unsigned ROUND8   = 127;
    localparam int unsigned OPAC_ONE = 65536;
    localparam int unsigned OPAC_MAX = 131071;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RAND_PHASES    = 6;
    localparam int          PHASE_ITEMS    = 225;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       written;
    } t_blend_px;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  cfg_we = 1'b0;
    logic  cfg_data = 1'b0;
    rsob_pkg::t_item pix_drv = '0;

    logic       o_busy;
    logic       o_valid;
    logic [7:0] o_out_red;
    logic [7:0] o_out_green;
    logic [7:0] o_out_blue;
    logic [7:0] o_out_alpha;
    logic       o_was_written;

    rsob_pkg::t_item pixel_q[$];
    t_blend_px       blended_q[$];
    bit        lock_mode = 1'b0;
    int        idle_pct = 0;
    int        mismatches = 0;
    int        n_results = 0;
    int        n_written = 0;
    int        n_locked = 0;
    int        idle_cycles = 0;

    rgba_source_over_blender_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (o_busy),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_paint_red     (pix_drv.paint_red),
        .i_paint_green   (pix_drv.paint_green),
        .i_paint_blue    (pix_drv.paint_blue),
        .i_paint_alpha   (pix_drv.paint_alpha),
        .i_paint_opacity (pix_drv.paint_opacity),
        .i_paint_covered (pix_drv.paint_covered),
        .i_dest_red      (pix_drv.dest_red),
        .i_dest_green    (pix_drv.dest_green),
        .i_dest_blue     (pix_drv.dest_blue),
        .i_dest_alpha    (pix_drv.dest_alpha),
        .o_valid         (o_valid),
        .o_out_red       (o_out_red),
        .o_out_green     (o_out_green),
        .o_out_blue      (o_out_blue),
        .o_out_alpha     (o_out_alpha),
        .o_was_written   (o_was_written)
    );

    always #5 i_clk = ~i_clk;

    // round(a * b / 255)
    function automatic int unsigned mul255(int unsigned a, int unsigned b);
        return (a * b + ROUND8) / FULL8;
    endfunction

    function automatic logic [7:0] over_chan(int unsigned s, int unsigned d, int unsigned ea);
        int unsigned v;
        v = s + mul255(d, FULL8 - ea);
        return (v > FULL8) ? 8'(FULL8) : 8'(v);
    endfunction

    function automatic logic [7:0] lerp_chan(int unsigned s, int unsigned d, int unsigned ea);
        return 8'((s * ea + d * (FULL8 - ea) + ROUND8) / FULL8);
    endfunction

    function automatic t_blend_px blend_pixel(rsob_pkg::t_item px, bit lock);
        t_blend_px   res;
        int unsigned op;
        int unsigned ea;
        int unsigned da;
        res.red     = px.dest_red;
        res.green   = px.dest_green;
        res.blue    = px.dest_blue;
        res.alpha   = px.dest_alpha;
        res.written = 1'b0;
        da = px.dest_alpha;
        op = px.paint_opacity;
        if (op > OPAC_ONE) begin
            op = OPAC_ONE;
        end
        if (px.paint_covered && op != 0 && px.paint_alpha != 0) begin
            ea = (px.paint_alpha * op + 32768) >> 16;
            if (ea > FULL8) begin
                ea = FULL8;
            end
            if (lock) begin
                // transparent destination stays untouched under alpha lock
                if (da != 0) begin
                    res.red     = lerp_chan(mul255(px.paint_red, da), px.dest_red, ea);
                    res.green   = lerp_chan(mul255(px.paint_green, da), px.dest_green, ea);
                    res.blue    = lerp_chan(mul255(px.paint_blue, da), px.dest_blue, ea);
                    res.written = 1'b1;
                end
            end else begin
                res.red     = over_chan(mul255(px.paint_red, ea), px.dest_red, ea);
                res.green   = over_chan(mul255(px.paint_green, ea), px.dest_green, ea);
                res.blue    = over_chan(mul255(px.paint_blue, ea), px.dest_blue, ea);
                res.alpha   = over_chan(ea, da, ea);
                res.written = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic rsob_pkg::t_item make_pixel(int pr, int pg, int pb, int pa, int op,
                                                   bit cov, int dr, int dg, int db, int da);
        rsob_pkg::t_item px;
        px.paint_red     = 8'(pr);
        px.paint_green   = 8'(pg);
        px.paint_blue    = 8'(pb);
        px.paint_alpha   = 8'(pa);
        px.paint_opacity = 17'(op);
        px.paint_covered = cov;
        px.dest_red      = 8'(dr);
        px.dest_green    = 8'(dg);
        px.dest_blue     = 8'(db);
        px.dest_alpha    = 8'(da);
        return px;
    endfunction

    function automatic void queue_pixel(rsob_pkg::t_item px);
        pixel_q.insert(pixel_q.size(), px);
    endfunction

    // channel value leaning toward the extremes
    function automatic int rand_chan();
        int r;
        r = $urandom_range(7);
        if (r == 0) return 0;
        if (r == 1) return 255;
        return $urandom_range(255);
    endfunction

    function automatic rsob_pkg::t_item rand_pixel();
        int pa;
        int op;
        int r;
        r = $urandom_range(9);
        pa = (r == 0) ? 0 : (r == 1) ? 255 : (r == 2) ? $urandom_range(1, 3) : rand_chan();
        r = $urandom_range(15);
        case (r)
            0:       op = 0;
            1:       op = OPAC_ONE;
            2:       op = $urandom_range(OPAC_ONE + 1, OPAC_MAX);
            3:       op = $urandom_range(1, 300);
            4:       op = $urandom_range(65000, OPAC_ONE - 1);
            default: op = $urandom_range(1, OPAC_ONE - 1);
        endcase
        return make_pixel(rand_chan(), rand_chan(), rand_chan(), pa, op,
                          $urandom_range(15) != 0,
                          rand_chan(), rand_chan(), rand_chan(), rand_chan());
    endfunction

    // driver: one item per accept, random sender gaps
    always @(posedge i_clk) begin : drv
        bit take;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            take = !start;
            if (start && !o_busy) begin
                blended_q.insert(blended_q.size(), blend_pixel(pix_drv, lock_mode));
                if (lock_mode) n_locked++;
                take = 1'b1;
            end
            if (take) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    pix_drv <= pixel_q.pop_front();
                    start   <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(string what, t_blend_px exp_px);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] MISMATCH %s: exp r=%0d g=%0d b=%0d a=%0d w=%0b, %s",
                     $realtime, what, exp_px.red, exp_px.green, exp_px.blue,
                     exp_px.alpha, exp_px.written,
                     $sformatf("got r=%0d g=%0d b=%0d a=%0d w=%0b", o_out_red,
                               o_out_green, o_out_blue, o_out_alpha, o_was_written));
        end
    endtask

    // monitor: results cannot be stalled, so check each strobe as it comes
    always @(posedge i_clk) begin : mon
        t_blend_px exp_px;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (o_was_written) n_written++;
            if (blended_q.size() == 0) begin
                exp_px = '{default: '0};
                note_mismatch("result with no pending item", exp_px);
            end else begin
                exp_px = blended_q.pop_front();
                if (o_out_red !== exp_px.red || o_out_green !== exp_px.green ||
                    o_out_blue !== exp_px.blue || o_out_alpha !== exp_px.alpha ||
                    o_was_written !== exp_px.written) begin
                    note_mismatch("pixel", exp_px);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !o_busy) || o_valid) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no progress for %0d cycles", $realtime, idle_cycles);
                $display("rgba_source_over_blender_unit verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // sampled mid-cycle, after the driver and monitor have settled
    task automatic drain();
        while (pixel_q.size() > 0 || start || blended_q.size() > 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_lock(bit v);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        lock_mode = v;
    endtask

    initial begin : seq
        bit lock_plan[RAND_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, normal mode
        write_lock(1'b0);
        idle_pct = 9;
        queue_pixel(make_pixel(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        queue_pixel(make_pixel(255, 255, 255, 255, OPAC_MAX, 0, 255, 255, 255, 255));
        queue_pixel(make_pixel(200, 100, 50, 255, 0, 1, 9, 8, 7, 6));
        queue_pixel(make_pixel(200, 100, 50, 0, OPAC_ONE, 1, 9, 8, 7, 6));
        queue_pixel(make_pixel(255, 0, 128, 255, OPAC_ONE, 1, 10, 20, 30, 40));
        queue_pixel(make_pixel(17, 34, 51, 255, OPAC_MAX, 1, 90, 80, 70, 200));
        queue_pixel(make_pixel(77, 66, 55, 200, OPAC_ONE + 1, 1, 1, 2, 3, 4));
        // opacity nonzero but rounds the alpha to zero
        queue_pixel(make_pixel(255, 255, 255, 1, 1, 1, 12, 34, 56, 78));
        queue_pixel(make_pixel(255, 255, 255, 128, OPAC_ONE, 1, 255, 255, 255, 255));
        queue_pixel(make_pixel(128, 64, 32, 100, 40000, 1, 0, 0, 0, 0));
        queue_pixel(make_pixel(255, 255, 255, 255, OPAC_MAX, 1, 255, 255, 255, 255));
        queue_pixel(make_pixel(170, 85, 240, 99, 12345, 1, 170, 85, 15, 130));
        drain();

        // directed, alpha locked
        write_lock(1'b1);
        queue_pixel(make_pixel(255, 128, 0, 255, OPAC_ONE, 1, 50, 60, 70, 0));
        queue_pixel(make_pixel(255, 128, 0, 255, OPAC_ONE, 1, 50, 60, 70, 255));
        queue_pixel(make_pixel(200, 150, 100, 200, 30000, 1, 40, 50, 60, 128));
        queue_pixel(make_pixel(200, 150, 100, 200, 30000, 0, 40, 50, 60, 128));
        queue_pixel(make_pixel(200, 150, 100, 1, 100, 1, 40, 50, 60, 100));
        queue_pixel(make_pixel(10, 20, 30, 180, OPAC_MAX, 1, 250, 240, 230, 220));
        queue_pixel(make_pixel(255, 255, 255, 255, OPAC_MAX, 1, 255, 255, 255, 255));
        queue_pixel(make_pixel(0, 0, 0, 255, OPAC_ONE, 1, 0, 0, 0, 0));
        queue_pixel(make_pixel(0, 0, 0, 255, OPAC_ONE, 1, 255, 255, 255, 1));
        drain();

        // random: sender gaps light, then heavy, then none
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_lock(lock_plan[ph]);
            idle_pct = (ph < 2) ? 9 : (ph < 4) ? 69 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                queue_pixel(rand_pixel());
            end
            drain();
        end

        repeat (rsob_pkg::C_LATENCY + 5) @(posedge i_clk);
        $display("%0d pixels checked, %0d written, %0d passed through, %0d alpha-locked",
                 n_results, n_written, n_results - n_written, n_locked);
        $display("sender gap rates 9%%, 69%% and 0%%; %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("rgba_source_over_blender_unit verification clean");
        end else begin
            $display("rgba_source_over_blender_unit verification failed");
        end
        $finish;
    end

endmodule
